[rtl/core/afk_pkg.sv]
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and CORDIC angle table for the arm kinematics core.
// ----------------------------------------------------------------------------
package afk_pkg;

  localparam int ANGLE_FRAC_BITS_DEF  = 14;
  localparam int LENGTH_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF    = 16;
  localparam int MAX_STAGES           = 24;

  // internal angle word, 2^-30 rad
  localparam int AW = 36;
  // CORDIC datapath width, Q30 plus guard
  localparam int CW = 33;

  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 33'sd652032874;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINK_FIRST = 8'd0,
    REG_LINK_LAST  = 8'd1,
    REG_X_OFFSET   = 8'd2,
    REG_Z_OFFSET   = 8'd3,
    REG_DEPTH_LIM  = 8'd4,
    REG_ANGLE_LIM  = 8'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DEPTH  = 3'd1,
    ST_JOINT1 = 3'd2,
    ST_JOINT2 = 3'd3,
    ST_JOINT3 = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0]        link_first;
    logic [15:0]        link_last;
    logic signed [16:0] x_offset;
    logic signed [16:0] z_offset;
    logic [15:0]        depth_limit;
    logic [14:0]        angle_limit;
  } cfg_t;

  // atan(2^-i) in 2^-30 rad
  function automatic logic [31:0] stage_angle(input int i);
    logic [31:0] tab [MAX_STAGES];
    tab = '{32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
            32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
            32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
            32'd262144,    32'd131072,    32'd65536,     32'd32768,
            32'd16384,     32'd8192,      32'd4096,      32'd2048,
            32'd1024,      32'd512,       32'd256,       32'd128};
    return tab[i];
  endfunction

endpackage

[rtl/core/afk_cordic.sv]
// ----------------------------------------------------------------------------
// afk_cordic
// Pipelined rotation-mode CORDIC: range reduction stage, then one register
// stage per micro-rotation, then the quadrant flip. Stalls with the pipe.
// ----------------------------------------------------------------------------
module afk_cordic import afk_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] angle,
  output logic signed [CW-1:0] cos_out,
  output logic signed [CW-1:0] sin_out
);
  localparam int N = (STAGES < MAX_STAGES) ? STAGES : MAX_STAGES;

  logic signed [AW-1:0] r_wrap, r_red;
  logic                 flip_c;

  always_comb begin
    r_wrap = angle;
    if (r_wrap >= PI_Q30) r_wrap = r_wrap - TWO_PI_Q30;
    if (r_wrap < -PI_Q30) r_wrap = r_wrap + TWO_PI_Q30;
    r_red  = r_wrap;
    flip_c = 1'b0;
    if (r_wrap > HALF_PI_Q30) begin
      r_red = r_wrap - PI_Q30;
      flip_c = 1'b1;
    end else if (r_wrap < -HALF_PI_Q30) begin
      r_red = r_wrap + PI_Q30;
      flip_c = 1'b1;
    end
  end

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [CW-1:0] zs [N+1];
  logic                 fl [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= CW'(r_red);
      fl[0] <= flip_c;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] t;
    assign t = CW'($signed({1'b0, stage_angle(i)}));
    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1] <= fl[i];
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - t;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= fl[N] ? -xs[N] : xs[N];
      sin_out <= fl[N] ? -ys[N] : ys[N];
    end
  end
endmodule

[rtl/core/afk_combine.sv]
// ----------------------------------------------------------------------------
// afk_combine
// Scales trig results by link lengths, sums, saturates and rounds quaternion.
// Two register stages: products, then sum and saturate.
// ----------------------------------------------------------------------------
module afk_combine import afk_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          l1,
  input  logic [15:0]          l2,
  input  logic signed [16:0]   xoff,
  input  logic signed [18:0]   pz_in,
  input  logic signed [CW-1:0] c1, s1, c2, s2, c3, s3, ch, sh,
  output logic signed [18:0]   pos_x,
  output logic signed [18:0]   pos_y,
  output logic signed [18:0]   pos_z,
  output logic signed [15:0]   quat_z,
  output logic signed [15:0]   quat_w
);
  localparam int PW = CW + 17;
  logic signed [PW-1:0] p [6];
  logic signed [16:0]   xoff_q;
  logic signed [18:0]   pz_q;
  logic signed [CW-1:0] ch_q, sh_q;

  function automatic logic signed [PW-1:0] mulr(input logic [15:0] l,
                                                 input logic signed [CW-1:0] t);
    logic signed [PW-1:0] m;
    m = $signed({1'b0, l}) * t;
    m = m + (PW'(1) <<< 29);
    return m >>> 30;
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [CW-1:0] t);
    logic signed [CW-1:0] r;
    r = (t + (CW'(1) <<< 14)) >>> 15;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= mulr(l1, c1); p[1] <= mulr(l1, c2); p[2] <= mulr(l2, c3);
      p[3] <= mulr(l1, s1); p[4] <= mulr(l1, s2); p[5] <= mulr(l2, s3);
      xoff_q <= xoff; pz_q <= pz_in; ch_q <= ch; sh_q <= sh;
    end
  end

  logic signed [PW+1:0] sx, sy;
  always_comb begin
    sx = PW'(p[0]) + p[1] + p[2] + xoff_q;
    sy = PW'(p[3]) + p[4] + p[5];
  end

  function automatic logic signed [18:0] sat19(input logic signed [PW+1:0] v);
    if (v > 262143) return 19'sh3ffff;
    if (v < -262144) return 19'sh40000;
    return v[18:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x  <= sat19(sx);
      pos_y  <= sat19(sy);
      pos_z  <= pz_q;
      quat_z <= q15(sh_q);
      quat_w <= q15(ch_q);
    end
  end
endmodule

[rtl/core/arm_forward_kinematics.sv]
// ----------------------------------------------------------------------------
// arm_forward_kinematics
// SCARA forward kinematics with depth and joint bound checks and yaw quaternion.
// ----------------------------------------------------------------------------
// Fully pipelined: one joint vector per cycle while the output is not stalled.
// Stages: input register, range reduction, one stage per CORDIC rotation,
// flip, product, sum. Four CORDIC pipes run side by side. The whole pipe
// advances when the output register is empty or being taken, so the rate
// is set by the downstream tready. Failed checks give zeros and a status code.
module arm_forward_kinematics import afk_pkg::*; #(
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES    = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // prismatic_depth[16:0], angle_one[32:17], angle_two[48:33], angle_three[64:49]
  input  logic [71:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status_code[2:0], pos_x[21:3], pos_y[40:22], pos_z[59:41],
  // quat_z[75:60], quat_w[91:76]
  output logic [95:0]          m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);
  localparam int N   = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int SC  = 30 - ANGLE_FRAC_BITS;

  cfg_t cfg;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_first  <= 16'd13107;
      cfg.link_last   <= 16'd16384;
      cfg.x_offset    <= 17'sd9273;
      cfg.z_offset    <= -17'sd11469;
      cfg.depth_limit <= 16'd23921;
      cfg.angle_limit <= 15'd25736;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINK_FIRST: cfg.link_first  <= cfg_data[15:0];
        REG_LINK_LAST:  cfg.link_last   <= cfg_data[15:0];
        REG_X_OFFSET:   cfg.x_offset    <= cfg_data[16:0];
        REG_Z_OFFSET:   cfg.z_offset    <= cfg_data[16:0];
        REG_DEPTH_LIM:  cfg.depth_limit <= cfg_data[15:0];
        REG_ANGLE_LIM:  cfg.angle_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [16:0] d;
  logic signed [15:0] q1, q2, q3;
  assign d  = s_axis_tdata[16:0];
  assign q1 = s_axis_tdata[32:17];
  assign q2 = s_axis_tdata[48:33];
  assign q3 = s_axis_tdata[64:49];

  // input register stage
  logic               v0;
  status_t            st0;
  logic signed [AW-1:0] a1, a2, a3, ah;
  logic signed [18:0] pz0;
  logic signed [17:0] lim;
  logic signed [17:0] qs;
  assign lim = $signed({3'b0, cfg.angle_limit});

  status_t st_c;
  always_comb begin
    st_c = ST_OK;
    if (d < 0 || d > $signed({1'b0, cfg.depth_limit})) st_c = ST_DEPTH;
    else if (q1 < -lim || q1 > lim) st_c = ST_JOINT1;
    else if (q2 < -lim || q2 > lim) st_c = ST_JOINT2;
    else if (q3 < -lim || q3 > lim) st_c = ST_JOINT3;
  end
  assign qs = 18'(q1) - 18'(q2) + 18'(q3);

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid;
    if (en) begin
      st0 <= st_c;
      a1  <= AW'(q1) <<< SC;
      a2  <= (AW'(q1) - AW'(q2)) <<< SC;
      a3  <= AW'(qs) <<< SC;
      ah  <= HALF_PI_Q30 + (AW'(qs) <<< (SC - 1));
      pz0 <= 19'(cfg.z_offset) - 19'(d);
    end
  end

  logic signed [CW-1:0] c1, s1, c2, s2, c3, s3, ch, sh;
  afk_cordic #(.STAGES(N)) u_c1 (.clk, .en, .angle(a1), .cos_out(c1), .sin_out(s1));
  afk_cordic #(.STAGES(N)) u_c2 (.clk, .en, .angle(a2), .cos_out(c2), .sin_out(s2));
  afk_cordic #(.STAGES(N)) u_c3 (.clk, .en, .angle(a3), .cos_out(c3), .sin_out(s3));
  afk_cordic #(.STAGES(N)) u_ch (.clk, .en, .angle(ah), .cos_out(ch), .sin_out(sh));

  // sideband delay line to match the CORDIC pipe (range reduction, rotations, flip) then combine (products, sum)
  localparam int DL = N + 2;
  logic               vd [DL+2];
  status_t            sd [DL+2];
  logic signed [18:0] zd [DL];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DL + 2; k++) vd[k] <= 1'b0;
    end else if (en) begin
      vd[0] <= v0;
      for (int k = 1; k < DL + 2; k++) vd[k] <= vd[k-1];
    end
    if (en) begin
      sd[0] <= st0;
      zd[0] <= pz0;
      for (int k = 1; k < DL + 2; k++) sd[k] <= sd[k-1];
      for (int k = 1; k < DL; k++) zd[k] <= zd[k-1];
    end
  end

  logic signed [18:0] px, py, pz;
  logic signed [15:0] qz, qw;
  afk_combine u_comb (
    .clk, .en, .l1(cfg.link_first), .l2(cfg.link_last), .xoff(cfg.x_offset),
    .pz_in(zd[DL-1]), .c1, .s1, .c2, .s2, .c3, .s3, .ch, .sh,
    .pos_x(px), .pos_y(py), .pos_z(pz), .quat_z(qz), .quat_w(qw)
  );

  logic ok;
  assign ok = (sd[DL+1] == ST_OK);
  assign m_axis_tvalid = vd[DL+1];
  assign m_axis_tdata  = {4'b0, ok ? qw : 16'sd0, ok ? qz : 16'sd0,
                          ok ? pz : 19'sd0, ok ? py : 19'sd0, ok ? px : 19'sd0,
                          sd[DL+1]};

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready not tied to output slot");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[91:3] == '0)
    else $error("error result not zeroed");
`endif
endmodule
